/* hw/rtl/memory_region_map_allocator_macros.svh */
// Assertion macros for the memory region map allocator.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef MEMORY_REGION_MAP_ALLOCATOR_MACROS_SVH
`define MEMORY_REGION_MAP_ALLOCATOR_MACROS_SVH

// cond holds at every edge out of reset
`define MRMAP_ASSERT_HOLDS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// same-cycle implication
`define MRMAP_ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MRMAP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/mrmap_pkg.sv */
// Types and constants of the memory region map allocator.
// No dependencies; used by the allocator and its testbench.
`default_nettype none

package mrmap_pkg;

	localparam logic [1:0] FUNC_ADD   = 2'd0;
	localparam logic [1:0] FUNC_ALLOC = 2'd1;
	localparam logic [1:0] FUNC_FREE  = 2'd2;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_NOFIT    = 2'd1;
	localparam logic [1:0] STAT_NOTFOUND = 2'd2;
	localparam logic [1:0] STAT_FULL     = 2'd3;

	localparam logic [1:0] CFG_AVAIL_TYPE = 2'd0;
	localparam logic [1:0] CFG_ALLOC_TYPE = 2'd1;
	localparam logic [1:0] CFG_CEILING    = 2'd2;

	localparam logic [63:0] LOW_MEM_TOP = 64'h0000_0000_000f_ffff;

	typedef struct packed {
		logic [63:0] start;
		logic [63:0] length;
		logic [7:0]  kind;
	} region_t;

	localparam int ENT_W = $bits(region_t);

	typedef struct packed {
		logic [1:0]  func;
		logic [63:0] region_address;
		logic [63:0] region_size;
		logic [7:0]  region_type;
		logic [31:0] alignment;
		logic [63:0] top_limit;
	} req_t;

	typedef struct packed {
		logic [63:0] result_address;
		logic [1:0]  status;
		logic [5:0]  entries_used;
	} rsp_t;

	typedef struct packed {
		logic [1:0]  index;
		logic [63:0] value;
	} cfg_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_ADD_WR,
		ST_ALC_RD,
		ST_ALC_CHK,
		ST_ALC_LIM,
		ST_ALC_DIV,
		ST_ALC_FIT,
		ST_ALC_WR,
		ST_ALC_APP,
		ST_FREE_RD,
		ST_FREE_CHK,
		ST_CMP_RD,
		ST_CMP_WR,
		ST_SRT_KEY_RD,
		ST_SRT_KEY,
		ST_SRT_RD,
		ST_SRT_CHK,
		ST_MRG_START,
		ST_MRG_FIRST,
		ST_MRG_RD,
		ST_MRG_CHK,
		ST_MRG_DO,
		ST_MRG_LAST,
		ST_RESP
	} state_t;

endpackage

`default_nettype wire

/* hw/rtl/mrmap_stream_if.sv */
// Valid/ready channel carrying one item of payload_t.
// No dependencies; the payload types come from mrmap_pkg where it is instantiated.
`default_nettype none

interface mrmap_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/mrmap_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mrmap_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

`default_nettype wire

/* hw/rtl/memory_region_map_allocator.sv */
// Memory region map allocator: sorted typed region table with add/alloc/free.
// Depends on mrmap_pkg, mrmap_stream_if, mrmap_ram and the macros header.
//
// Channels: req (sink) takes one item per operation, rsp (source) returns one
// item per request, cfg (sink, always ready) writes available_type,
// alloc_type and address_ceiling; write it only while the block is idle.
// One request at a time: req.ready is high only in the idle state.
// add and free run a compaction pass, an insertion sort by start address and a
// merge pass over the entries in the table; free first scans for its entry.
// alloc scans the regions; a region passing the type, size and limit checks
// goes through the 64-step remainder unit (one bit a cycle), then the fit
// check, and the chosen one is split and the new entry appended before the
// compaction, sort and merge passes.
// The table sits in one RAM port pair; each pass reads the entries one at a time.
// Reset empties the table (count to zero) and restores the register
// defaults; table contents need no clearing.
// If rsp stalls, the finished result waits in the output register and the
// block holds in its response state until that register is free.
`default_nettype none
`include "memory_region_map_allocator_macros.svh"

module memory_region_map_allocator
	import mrmap_pkg::*;
#(
	parameter int MAX_REGIONS = 32
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	mrmap_stream_if.sink   req,
	mrmap_stream_if.source rsp,
	mrmap_stream_if.sink   cfg
);
	localparam int CNT_W = $clog2(MAX_REGIONS + 1);
	localparam int AW    = $clog2(MAX_REGIONS);

	state_t state_q, state_d;

	logic [CNT_W-1:0] cnt_q, k_q, w_q, j_q, skip_q;
	logic             skip_en_q;
	logic [7:0]       avail_q, alloc_q;
	logic [63:0]      ceil_q;

	logic [63:0] addr_q, size_q, limit_q;
	logic [7:0]  kind_q;
	logic [31:0] align_q;
	logic [63:0] result_q;
	logic [1:0]  status_q;

	region_t     cur_q, key_q, b_q;
	logic [63:0] base_q, dvd_q, top_q, bend_q;
	logic [31:0] rem_q;
	logic [5:0]  dcnt_q;

	logic rsp_valid_q;
	rsp_t rsp_data_q;

	logic             ram_we;
	logic [AW-1:0]    ram_waddr, ram_raddr;
	logic [ENT_W-1:0] ram_wdata, ram_rdata;
	region_t          rd_e;

	mrmap_ram #(
		.WIDTH(ENT_W),
		.DEPTH(MAX_REGIONS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rd_e = region_t'(ram_rdata);

	logic full, req_hit;
	assign full    = (cnt_q == CNT_W'(MAX_REGIONS));
	assign req_hit = req.valid && req.ready;

	// remainder unit
	logic [32:0] div_d, div_t;
	logic        div_ge;
	logic [63:0] fit_base;
	assign div_d    = (align_q == 32'd0) ? 33'd1 : {1'b0, align_q};
	assign div_t    = {rem_q, dvd_q[63]};
	assign div_ge   = (div_t >= div_d);
	assign fit_base = base_q - {32'd0, rem_q};

	logic alc_ok;
	assign alc_ok = (cur_q.kind == avail_q) && (cur_q.length >= size_q) &&
		(base_q < limit_q) && !((limit_q > LOW_MEM_TOP) && (base_q <= LOW_MEM_TOP));

	// merge step on cur (a) and b
	logic        mrg_drop, mrg_gap, mrg_same, mrg_join, mrg_adj, mrg_adv;
	logic [63:0] ov, mrg_end, mrg_len;
	region_t     a_out, b_out;
	always_comb begin
		mrg_drop = (cur_q.length == 64'd0);
		mrg_gap  = (top_q < b_q.start);
		mrg_same = (cur_q.kind == b_q.kind);
		ov       = top_q - b_q.start;
		mrg_join = !mrg_drop && !mrg_gap && mrg_same && (cur_q.kind != alloc_q);
		mrg_adj  = !mrg_drop && !mrg_gap && !mrg_same && (ov != 64'd0);
		mrg_adv  = !mrg_drop && !mrg_join;
		mrg_end  = (top_q > bend_q) ? top_q : bend_q;
		mrg_len  = mrg_end - cur_q.start;
		a_out    = cur_q;
		b_out    = b_q;
		if (mrg_adj) begin
			if (cur_q.kind > b_q.kind) begin
				b_out.start  = top_q;
				b_out.length = (ov >= b_q.length) ? 64'd0 : (b_q.length - ov);
			end else begin
				a_out.length = b_q.start - cur_q.start;
			end
		end
	end

	logic srt_gt;
	assign srt_gt = (rd_e.start > key_q.start);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					case (req.data.func)
						FUNC_ADD:   state_d = full ? ST_RESP : ST_ADD_WR;
						FUNC_ALLOC: state_d = ((req.data.region_size == 64'd0) || full) ?
							ST_RESP : ST_ALC_RD;
						FUNC_FREE:  state_d = ST_FREE_RD;
						default:    state_d = ST_RESP;
					endcase
				end
			end
			ST_ADD_WR:     state_d = ST_CMP_RD;
			ST_ALC_RD:     state_d = (k_q == cnt_q) ? ST_RESP : ST_ALC_CHK;
			ST_ALC_CHK:    state_d = ST_ALC_LIM;
			ST_ALC_LIM:    state_d = alc_ok ? ST_ALC_DIV : ST_ALC_RD;
			ST_ALC_DIV:    state_d = (dcnt_q == 6'd63) ? ST_ALC_FIT : ST_ALC_DIV;
			ST_ALC_FIT:    state_d = (fit_base < cur_q.start) ? ST_ALC_RD : ST_ALC_WR;
			ST_ALC_WR:     state_d = ST_ALC_APP;
			ST_ALC_APP:    state_d = ST_CMP_RD;
			ST_FREE_RD:    state_d = (k_q == cnt_q) ? ST_RESP : ST_FREE_CHK;
			ST_FREE_CHK:   state_d = (rd_e.start == addr_q) ? ST_CMP_RD : ST_FREE_RD;
			ST_CMP_RD:     state_d = (k_q == cnt_q) ? ST_SRT_KEY_RD : ST_CMP_WR;
			ST_CMP_WR:     state_d = ST_CMP_RD;
			ST_SRT_KEY_RD: state_d = (k_q >= cnt_q) ? ST_MRG_START : ST_SRT_KEY;
			ST_SRT_KEY:    state_d = ST_SRT_RD;
			ST_SRT_RD:     state_d = (j_q == '0) ? ST_SRT_KEY_RD : ST_SRT_CHK;
			ST_SRT_CHK:    state_d = srt_gt ? ST_SRT_RD : ST_SRT_KEY_RD;
			ST_MRG_START:  state_d = (cnt_q == '0) ? ST_RESP : ST_MRG_FIRST;
			ST_MRG_FIRST:  state_d = ST_MRG_RD;
			ST_MRG_RD:     state_d = (k_q == cnt_q) ? ST_MRG_LAST : ST_MRG_CHK;
			ST_MRG_CHK:    state_d = ST_MRG_DO;
			ST_MRG_DO:     state_d = ST_MRG_RD;
			ST_MRG_LAST:   state_d = ST_RESP;
			ST_RESP:       state_d = (!rsp_valid_q || rsp.ready) ? ST_IDLE : ST_RESP;
			default:       state_d = ST_IDLE;
		endcase
	end

	// outputs: table port and handshakes
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_raddr = '0;
		case (state_q)
			ST_ADD_WR: begin
				ram_we    = 1'b1;
				ram_waddr = cnt_q[AW-1:0];
				ram_wdata = {addr_q, size_q, kind_q};
			end
			ST_ALC_RD, ST_FREE_RD, ST_CMP_RD, ST_SRT_KEY_RD, ST_MRG_RD: begin
				ram_raddr = k_q[AW-1:0];
			end
			ST_ALC_WR: begin
				ram_we    = 1'b1;
				ram_waddr = k_q[AW-1:0];
				ram_wdata = {cur_q.start, base_q - cur_q.start, cur_q.kind};
			end
			ST_ALC_APP: begin
				ram_we    = 1'b1;
				ram_waddr = cnt_q[AW-1:0];
				ram_wdata = {base_q, size_q, kind_q};
			end
			ST_CMP_WR: begin
				ram_we    = (rd_e.length != 64'd0) && !(skip_en_q && (k_q == skip_q));
				ram_waddr = w_q[AW-1:0];
				ram_wdata = ram_rdata;
			end
			ST_SRT_RD: begin
				ram_we    = (j_q == '0);
				ram_waddr = j_q[AW-1:0];
				ram_wdata = key_q;
				ram_raddr = j_q[AW-1:0] - AW'(1);
			end
			ST_SRT_CHK: begin
				ram_we    = 1'b1;
				ram_waddr = j_q[AW-1:0];
				ram_wdata = srt_gt ? ram_rdata : key_q;
			end
			ST_MRG_DO: begin
				ram_we    = mrg_adv && (a_out.length != 64'd0);
				ram_waddr = w_q[AW-1:0];
				ram_wdata = a_out;
			end
			ST_MRG_LAST: begin
				ram_we    = (cur_q.length != 64'd0);
				ram_waddr = w_q[AW-1:0];
				ram_wdata = cur_q;
			end
			default: begin
			end
		endcase
	end

	assign req.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

	logic [CNT_W+5:0] cnt_ext;
	assign cnt_ext = {6'd0, cnt_q};

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
			avail_q     <= 8'd1;
			alloc_q     <= 8'd6;
			ceil_q      <= '1;
		end else begin
			state_q <= state_d;
			if (cfg.valid) begin
				case (cfg.data.index)
					CFG_AVAIL_TYPE: avail_q <= cfg.data.value[7:0];
					CFG_ALLOC_TYPE: alloc_q <= cfg.data.value[7:0];
					CFG_CEILING:    ceil_q  <= cfg.data.value;
					default: begin
					end
				endcase
			end
			if ((state_q == ST_RESP) && (!rsp_valid_q || rsp.ready)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.valid && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_ADD_WR, ST_ALC_APP: cnt_q <= cnt_q + CNT_W'(1);
				ST_CMP_RD: begin
					if (k_q == cnt_q) begin
						cnt_q <= w_q;
					end
				end
				ST_MRG_LAST: cnt_q <= w_q + CNT_W'(cur_q.length != 64'd0);
				default: begin
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (req_hit) begin
					addr_q    <= req.data.region_address;
					size_q    <= req.data.region_size;
					kind_q    <= req.data.region_type;
					align_q   <= req.data.alignment;
					limit_q   <= (req.data.top_limit > ceil_q) ? ceil_q : req.data.top_limit;
					result_q  <= '0;
					skip_en_q <= 1'b0;
					k_q       <= '0;
					w_q       <= '0;
					case (req.data.func)
						FUNC_ADD: begin
							status_q <= full ? STAT_FULL : STAT_OK;
							if (req.data.region_size > ~req.data.region_address) begin
								size_q <= ~req.data.region_address;
							end
						end
						FUNC_ALLOC: status_q <= (full && (req.data.region_size != 64'd0)) ?
							STAT_FULL : STAT_NOFIT;
						FUNC_FREE:  status_q <= STAT_NOTFOUND;
						default:    status_q <= STAT_OK;
					endcase
				end
			end
			ST_ALC_CHK: begin
				cur_q  <= rd_e;
				base_q <= rd_e.start + rd_e.length;
			end
			ST_ALC_LIM: begin
				if (alc_ok) begin
					base_q <= base_q - size_q;
					dvd_q  <= base_q - size_q;
					rem_q  <= '0;
					dcnt_q <= '0;
				end else begin
					k_q <= k_q + CNT_W'(1);
				end
			end
			ST_ALC_DIV: begin
				rem_q  <= div_ge ? 32'(div_t - div_d) : div_t[31:0];
				dvd_q  <= {dvd_q[62:0], 1'b0};
				dcnt_q <= dcnt_q + 6'd1;
			end
			ST_ALC_FIT: begin
				if (fit_base < cur_q.start) begin
					k_q <= k_q + CNT_W'(1);
				end else begin
					base_q <= fit_base;
				end
			end
			ST_ADD_WR: begin
				k_q <= '0;
				w_q <= '0;
			end
			ST_ALC_APP: begin
				result_q <= base_q;
				status_q <= STAT_OK;
				k_q      <= '0;
				w_q      <= '0;
			end
			ST_FREE_CHK: begin
				if (rd_e.start == addr_q) begin
					skip_en_q <= 1'b1;
					skip_q    <= k_q;
					status_q  <= STAT_OK;
					k_q       <= '0;
					w_q       <= '0;
				end else begin
					k_q <= k_q + CNT_W'(1);
				end
			end
			ST_CMP_RD: begin
				if (k_q == cnt_q) begin
					k_q <= CNT_W'(1);
				end
			end
			ST_CMP_WR: begin
				if (ram_we) begin
					w_q <= w_q + CNT_W'(1);
				end
				k_q <= k_q + CNT_W'(1);
			end
			ST_SRT_KEY_RD: j_q <= k_q;
			ST_SRT_KEY:    key_q <= rd_e;
			ST_SRT_RD: begin
				if (j_q == '0) begin
					k_q <= k_q + CNT_W'(1);
				end
			end
			ST_SRT_CHK: begin
				if (srt_gt) begin
					j_q <= j_q - CNT_W'(1);
				end else begin
					k_q <= k_q + CNT_W'(1);
				end
			end
			ST_MRG_START: begin
				k_q <= CNT_W'(1);
				w_q <= '0;
			end
			ST_MRG_FIRST: cur_q <= rd_e;
			ST_MRG_CHK: begin
				b_q    <= rd_e;
				top_q  <= cur_q.start + cur_q.length;
				bend_q <= rd_e.start + rd_e.length;
			end
			ST_MRG_DO: begin
				k_q <= k_q + CNT_W'(1);
				if (mrg_drop) begin
					cur_q <= b_q;
				end else if (mrg_join) begin
					cur_q.length <= mrg_len;
				end else begin
					cur_q <= b_out;
					if (a_out.length != 64'd0) begin
						w_q <= w_q + CNT_W'(1);
					end
				end
			end
			ST_RESP: begin
				if (!rsp_valid_q || rsp.ready) begin
					rsp_data_q.result_address <= result_q;
					rsp_data_q.status         <= status_q;
					rsp_data_q.entries_used   <= cnt_ext[5:0];
				end
			end
			default: begin
			end
		endcase
	end

	`MRMAP_ASSERT_HOLDS(a_cnt_range, cnt_q <= CNT_W'(MAX_REGIONS), "region count past table size")
	`MRMAP_ASSERT_IMPLIES(a_rem_below_div, state_q == ST_ALC_DIV, 33'(rem_q) < div_d, "remainder not reduced")
	`MRMAP_ASSERT_IMPLIES(a_wr_behind_rd, state_q == ST_CMP_WR || state_q == ST_MRG_DO, w_q <= k_q, "write pointer overtook read pointer")
	`MRMAP_ASSERT_NEXT(a_rsp_load, state_q == ST_RESP && (!rsp_valid_q || rsp.ready), rsp_valid_q && state_q == ST_IDLE, "result item not presented")

endmodule

`default_nettype wire

/* tb/memory_region_map_allocator_tb.sv */
// Self-checking testbench of memory_region_map_allocator: add, alloc, free and
// unused-function requests run against a behavioural model of the region table in a scoreboard.
// Depends on mrmap_pkg, mrmap_stream_if and the block's RTL.
`timescale 1ns / 100ps

module memory_region_map_allocator_tb;
	import mrmap_pkg::*;

	localparam int TABLE_DEPTH = 32;
	localparam logic [1:0] FUNC_NONE = 2'd3;
	localparam logic [63:0] ALL_ONES = 64'hffff_ffff_ffff_ffff;

	class region_map_scoreboard;
		logic [63:0] starts[TABLE_DEPTH];
		logic [63:0] lengths[TABLE_DEPTH];
		logic [7:0]  kinds[TABLE_DEPTH];
		int          used;
		logic [7:0]  free_kind;
		logic [7:0]  block_kind;
		logic [63:0] ceiling;
		rsp_t        expected_responses[$];
		int          mismatches;

		function new();
			used = 0;
			free_kind = 8'd1;
			block_kind = 8'd6;
			ceiling = ALL_ONES;
			mismatches = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [63:0] value);
			case (idx)
				CFG_AVAIL_TYPE: free_kind = value[7:0];
				CFG_ALLOC_TYPE: block_kind = value[7:0];
				CFG_CEILING: ceiling = value;
				default: ;
			endcase
		endfunction

		function void drop_entry(int at);
			if (at >= used)
				return;
			used--;
			for (int k = at; k < used; k++) begin
				starts[k] = starts[k + 1];
				lengths[k] = lengths[k + 1];
				kinds[k] = kinds[k + 1];
			end
		endfunction

		function void drop_empties();
			int k;
			k = 0;
			while (k < used) begin
				if (lengths[k] == 0)
					drop_entry(k);
				else
					k++;
			end
		endfunction

		function void sort_by_start();
			logic [63:0] s, l;
			logic [7:0]  t;
			int j;
			for (int k = 1; k < used; k++) begin
				s = starts[k];
				l = lengths[k];
				t = kinds[k];
				j = k;
				while (j > 0 && starts[j - 1] > s) begin
					starts[j] = starts[j - 1];
					lengths[j] = lengths[j - 1];
					kinds[j] = kinds[j - 1];
					j--;
				end
				starts[j] = s;
				lengths[j] = l;
				kinds[j] = t;
			end
		endfunction

		function void normalize();
			logic [63:0] top, nxt_end, ov;
			drop_empties();
			sort_by_start();
			for (int i = 0; i + 1 < used; i++) begin
				if (lengths[i] == 0) begin
					drop_entry(i);
					i--;
					continue;
				end
				top = starts[i] + lengths[i];
				if (top < starts[i + 1])
					continue;
				if (kinds[i] == kinds[i + 1]) begin
					if (kinds[i] == block_kind)
						continue;
					nxt_end = starts[i + 1] + lengths[i + 1];
					if (top > nxt_end)
						nxt_end = top;
					starts[i + 1] = starts[i];
					lengths[i + 1] = nxt_end - starts[i];
					drop_entry(i);
					i--;
				end else begin
					ov = top - starts[i + 1];
					if (ov == 0)
						continue;
					if (kinds[i] > kinds[i + 1]) begin
						if (ov >= lengths[i + 1]) begin
							starts[i + 1] = top;
							lengths[i + 1] = 0;
						end else begin
							starts[i + 1] += ov;
							lengths[i + 1] -= ov;
						end
					end else begin
						lengths[i] = starts[i + 1] - starts[i];
					end
				end
			end
			drop_empties();
		endfunction

		function void append_entry(logic [63:0] s, logic [63:0] l, logic [7:0] t);
			if (used >= TABLE_DEPTH)
				return;
			starts[used] = s;
			lengths[used] = l;
			kinds[used] = t;
			used++;
		endfunction

		function void note_request(req_t r);
			rsp_t        e;
			logic [63:0] sz, lim, align, reg_end, base;
			e.result_address = '0;
			e.status = STAT_OK;
			sz = r.region_size;
			case (r.func)
				FUNC_ADD: begin
					if (used >= TABLE_DEPTH) begin
						e.status = STAT_FULL;
					end else begin
						if (sz > ~r.region_address)
							sz = ~r.region_address;
						append_entry(r.region_address, sz, r.region_type);
						normalize();
					end
				end
				FUNC_ALLOC: begin
					if (sz == 0) begin
						e.status = STAT_NOFIT;
					end else if (used >= TABLE_DEPTH) begin
						e.status = STAT_FULL;
					end else begin
						e.status = STAT_NOFIT;
						align = (r.alignment == 0) ? 64'd1 : {32'd0, r.alignment};
						lim = (r.top_limit > ceiling) ? ceiling : r.top_limit;
						for (int k = 0; k < used; k++) begin
							if (kinds[k] != free_kind || lengths[k] < sz)
								continue;
							reg_end = starts[k] + lengths[k];
							if (reg_end >= lim)
								continue;
							if (lim > LOW_MEM_TOP && reg_end <= LOW_MEM_TOP)
								continue;
							base = reg_end - sz;
							base -= base % align;
							if (base < starts[k])
								continue;
							lengths[k] = base - starts[k];
							append_entry(base, sz, r.region_type);
							normalize();
							e.result_address = base;
							e.status = STAT_OK;
							break;
						end
					end
				end
				FUNC_FREE: begin
					e.status = STAT_NOTFOUND;
					for (int k = 0; k < used; k++) begin
						if (starts[k] == r.region_address) begin
							drop_entry(k);
							normalize();
							e.status = STAT_OK;
							break;
						end
					end
				end
				default: ;
			endcase
			e.entries_used = used[5:0];
			expected_responses.push_back(e);
		endfunction

		function void check_response(rsp_t got);
			rsp_t e;
			if (expected_responses.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected response %p", got);
				return;
			end
			e = expected_responses.pop_front();
			if (got.result_address !== e.result_address || got.status !== e.status
					|| got.entries_used !== e.entries_used) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: address exp %h got %h, status exp %0d got %0d, entries exp %0d got %0d",
						e.result_address, got.result_address, e.status, got.status,
						e.entries_used, got.entries_used);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	mrmap_stream_if #(.payload_t(req_t)) req_if();
	mrmap_stream_if #(.payload_t(rsp_t)) rsp_if();
	mrmap_stream_if #(.payload_t(cfg_t)) cfg_if();

	memory_region_map_allocator dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if),
		.cfg(cfg_if)
	);

	region_map_scoreboard sb = new();
	bit idling_on;
	int responses_seen;

	always #10 clk = ~clk;

	initial begin
		#300ms;
		$display("memory_region_map_allocator regression: fail");
		$finish;
	end

	// response side: random stalls, one long hold-off to back the block up
	initial begin
		int stall;
		bit held;
		held = 0;
		responses_seen = 0;
		rsp_if.ready = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			stall = idling_on ? $urandom_range(0, 3) : 0;
			if (responses_seen == 60 && !held) begin
				stall = 400;
				held = 1;
			end
			if (stall != 0) begin
				rsp_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_if.ready <= 1'b1;
			do @(posedge clk); while (!rsp_if.valid);
			sb.check_response(rsp_if.data);
			responses_seen++;
		end
	end

	task automatic send(req_t r);
		int gap;
		gap = idling_on ? $urandom_range(0, 3) : 0;
		if (gap != 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.data <= r;
		do @(posedge clk); while (!req_if.ready);
		sb.note_request(r);
	endtask

	task automatic send_op(logic [1:0] f, logic [63:0] a, logic [63:0] s, logic [7:0] t,
			logic [31:0] al, logic [63:0] lim);
		req_t r;
		r.func = f;
		r.region_address = a;
		r.region_size = s;
		r.region_type = t;
		r.alignment = al;
		r.top_limit = lim;
		send(r);
	endtask

	task automatic drain();
		req_if.valid <= 1'b0;
		do @(posedge clk); while (sb.expected_responses.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [63:0] value);
		cfg_t c;
		c.index = idx;
		c.value = value;
		cfg_if.valid <= 1'b1;
		cfg_if.data <= c;
		do @(posedge clk); while (!cfg_if.ready);
		sb.write_reg(idx, value);
		cfg_if.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_regs(logic [7:0] avail, logic [7:0] blk, logic [63:0] ceil);
		write_reg(CFG_AVAIL_TYPE, {56'd0, avail});
		write_reg(CFG_ALLOC_TYPE, {56'd0, blk});
		write_reg(CFG_CEILING, ceil);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	function automatic logic [63:0] near_addr();
		return {42'd0, 22'($urandom_range(0, 1023)) << 12} + 64'h80000 * $urandom_range(0, 8);
	endfunction

	function automatic logic [7:0] pick_kind();
		case ($urandom_range(0, 4))
			0: return sb.free_kind;
			1: return sb.block_kind;
			2: return 8'($urandom_range(0, 7));
			3: return 8'($urandom());
			default: return sb.free_kind;
		endcase
	endfunction

	task automatic random_item();
		logic [63:0] a, s, lim;
		logic [31:0] al;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			a = ($urandom_range(0, 9) < 8) ? near_addr() : rand64();
			case ($urandom_range(0, 9))
				0: s = 64'd0;
				1: s = rand64();
				default: s = 64'($urandom_range(1, 32'h200000));
			endcase
			send_op(FUNC_ADD, a, s, pick_kind(), 32'd0, 64'd0);
		end else if (pick < 75) begin
			case ($urandom_range(0, 9))
				0: s = 64'd0;
				1: s = rand64();
				default: s = 64'($urandom_range(1, 32'h10000));
			endcase
			case ($urandom_range(0, 4))
				0: al = 32'd0;
				1: al = 32'd1;
				2: al = 32'd1 << $urandom_range(0, 31);
				3: al = $urandom();
				default: al = 32'h1000;
			endcase
			case ($urandom_range(0, 4))
				0: lim = ALL_ONES;
				1: lim = near_addr();
				2: lim = LOW_MEM_TOP;
				3: lim = rand64();
				default: lim = ALL_ONES;
			endcase
			send_op(FUNC_ALLOC, rand64(), s, pick_kind(), al, lim);
		end else if (pick < 95) begin
			if (sb.used > 0 && $urandom_range(0, 9) < 8)
				a = sb.starts[$urandom_range(0, sb.used - 1)];
			else
				a = ($urandom_range(0, 1)) ? near_addr() : rand64();
			send_op(FUNC_FREE, a, rand64(), 8'($urandom()), $urandom(), rand64());
		end else begin
			send_op(FUNC_NONE, rand64(), rand64(), 8'($urandom()), $urandom(), rand64());
		end
	endtask

	task automatic random_phase(int count);
		for (int n = 0; n < count; n++) begin
			if (n % 50 == 0)
				idling_on = $urandom_range(0, 3) != 0;
			random_item();
		end
		drain();
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		idling_on = 1'b1;
		req_if.valid = 1'b0;
		req_if.data = '0;
		cfg_if.valid = 1'b0;
		cfg_if.data = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_regs(8'd1, 8'd6, ALL_ONES);
		send_op(FUNC_ADD, 64'h0, 64'h0, 8'd1, 32'd0, 64'd0);
		send_op(FUNC_ADD, ALL_ONES - 64'hff, ALL_ONES, 8'd2, 32'd0, 64'd0);
		send_op(FUNC_ADD, 64'h1000, 64'h9f000, 8'd1, 32'd0, 64'd0);
		send_op(FUNC_ADD, 64'h100000, 64'h100000, 8'd1, 32'd0, 64'd0);
		send_op(FUNC_ADD, 64'h200000, 64'h100000, 8'd1, 32'd0, 64'd0);
		send_op(FUNC_ADD, 64'h280000, 64'h10000, 8'd4, 32'd0, 64'd0);
		send_op(FUNC_ADD, 64'h2f0000, 64'h40000, 8'd3, 32'd0, 64'd0);
		send_op(FUNC_ADD, 64'h2e0000, 64'h80000, 8'd5, 32'd0, 64'd0);
		send_op(FUNC_ADD, 64'h400000, 64'h10000, 8'd0, 32'd0, 64'd0);
		send_op(FUNC_ADD, 64'h408000, 64'h10000, 8'd255, 32'd0, 64'd0);
		send_op(FUNC_ALLOC, 64'h0, 64'h0, 8'd6, 32'd0, ALL_ONES);
		send_op(FUNC_ALLOC, 64'h0, 64'h1000, 8'd6, 32'h1000, ALL_ONES);
		send_op(FUNC_ALLOC, 64'h0, 64'h1000, 8'd6, 32'h1000, ALL_ONES);
		send_op(FUNC_ALLOC, 64'h0, 64'h123, 8'd6, 32'd0, ALL_ONES);
		send_op(FUNC_ALLOC, 64'h0, 64'h500, 8'd7, 32'd3, ALL_ONES);
		send_op(FUNC_ALLOC, 64'h0, 64'h800, 8'd6, 32'hffff_ffff, 64'h300000);
		send_op(FUNC_ALLOC, 64'h0, 64'h2000, 8'd6, 32'h10, LOW_MEM_TOP);
		send_op(FUNC_ALLOC, 64'h0, ALL_ONES, 8'd6, 32'd1, ALL_ONES);
		send_op(FUNC_ALLOC, 64'h0, 64'h1000, 8'd6, 32'd1, 64'h0);
		send_op(FUNC_FREE, 64'h100000, 64'h0, 8'd0, 32'd0, 64'd0);
		send_op(FUNC_FREE, 64'h12345, 64'h0, 8'd0, 32'd0, 64'd0);
		send_op(FUNC_NONE, ALL_ONES, ALL_ONES, 8'hff, 32'hffff_ffff, ALL_ONES);
		drain();

		random_phase(300);
		set_regs(8'd0, 8'd255, 64'h0000_0000_ffff_ffff);
		random_phase(250);
		set_regs(8'd255, 8'd0, 64'd0);
		random_phase(100);
		set_regs(8'd1, 8'd6, LOW_MEM_TOP);
		random_phase(100);
		set_regs(8'd1, 8'd6, ALL_ONES);
		random_phase(300);

		repeat (50) @(posedge clk);
		if (sb.mismatches == 0 && sb.expected_responses.size() == 0) begin
			$display("memory_region_map_allocator regression: pass");
		end else begin
			$display("memory_region_map_allocator regression: fail");
		end
		$finish;
	end

endmodule
